FILE: rtl/lps_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// lps_pkg
// Shared types, mode codes and arithmetic helpers for the LED pattern scanner.
// ----------------------------------------------------------------------------
package lps_pkg;

  // Animation mode codes (4-bit register value)
  localparam logic [3:0] MODE_RED_ROWS    = 4'd0;
  localparam logic [3:0] MODE_ORANGE_ROWS = 4'd1;
  localparam logic [3:0] MODE_GREEN_ROWS  = 4'd2;
  localparam logic [3:0] MODE_MULTI_ROWS  = 4'd3;
  localparam logic [3:0] MODE_RANDOM_ROWS = 4'd4;
  localparam logic [3:0] MODE_GREEN_COLS  = 4'd5;
  localparam logic [3:0] MODE_ORANGE_COLS = 4'd6;
  localparam logic [3:0] MODE_RED_COLS    = 4'd7;
  localparam logic [3:0] MODE_MULTI_COLS  = 4'd8;
  localparam logic [3:0] MODE_FADE        = 4'd9;
  localparam logic [3:0] MODE_SLEEP       = 4'd10;
  localparam logic [3:0] MODE_FLASH       = 4'd11;

  // Update intervals in ms
  localparam logic [31:0] WAIT_NORMAL = 32'd9;
  localparam logic [31:0] WAIT_SLEEP  = 32'd29;
  localparam logic [31:0] WAIT_FLASH  = 32'd50;

  // Triangle wave geometry
  localparam int ROW_PHASE     = 13;
  localparam int COL_PHASE     = 50;
  localparam int OFF_ROW       = 100;
  localparam int OFF_ORANGE    = 110;
  localparam int OFF_MULTI_ODD = 126;
  localparam int OFF_COL       = 50;
  localparam int OFF_COL_ODD   = 100;
  localparam int OFF_SLEEP     = 50;
  // 2^16 mod 200: correction when the 16-bit phase argument wraps
  localparam logic [9:0] WRAP_REM = 10'(65536 % 200);

  localparam int PERIOD    = 200;
  localparam int PWM_STEPS = 50;
  localparam int RAND_CELLS = 24;

  // Brightness level storage
  typedef logic signed [6:0] level_t;

  // Per-item control broadcast to all cells
  typedef struct packed {
    logic        upd;        // animation step on this item
    logic [3:0]  mode;
    logic [15:0] n_lo;       // step count, low 16 bits
    logic [7:0]  n_m16;      // n_lo mod 200
    logic [5:0]  n_m50;      // step count mod 50
    logic        mask_load;  // random rows: reload masks
    logic        fade_load;  // fade: roll new picks
  } lps_ctrl_t;

  // Reduce a value below 800 modulo 200
  function automatic logic [7:0] mod200_f(input logic [9:0] x);
    logic [9:0] y;
    y = x;
    if (y >= 10'd400) y = y - 10'd400;
    if (y >= 10'd200) y = y - 10'd200;
    return 8'(y);
  endfunction

  // Clamp to the 7-bit signed level range
  function automatic level_t sat_f(input logic signed [8:0] v);
    level_t r;
    if (v > 9'sd63)       r = 7'sd63;
    else if (v < -9'sd64) r = -7'sd64;
    else                  r = 7'(v);
    return r;
  endfunction

endpackage
`default_nettype wire

FILE: rtl/lps_seq.sv
`default_nettype none
// ----------------------------------------------------------------------------
// lps_seq
// Time check, step counter residues and scan tick counters.
// ----------------------------------------------------------------------------
module lps_seq
  import lps_pkg::*;
#(
  parameter int NUM_ROWS = 3,
  localparam int RW = (NUM_ROWS > 1) ? $clog2(NUM_ROWS) : 1
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          adv_i,
  input  wire logic [31:0]   time_ms_i,
  input  wire logic [3:0]    mode_i,
  input  wire logic          cfg_clr_i,
  output lps_ctrl_t          ctrl_o,
  output logic [RW-1:0]      row_o,
  output logic [5:0]         rem_o
);

  logic [15:0]   n_lo_q, n_lo_d;
  logic [15:0]   n_hi_q, n_hi_d;
  logic [7:0]    n_m16_q, n_m16_d;
  logic [7:0]    n_m200_q, n_m200_d;
  logic [31:0]   last_update_q, last_update_d;
  logic [31:0]   time_seen_q, time_seen_d;
  logic [31:0]   tick_cnt_q, tick_cnt_d;
  logic [5:0]    tick_m50_q, tick_m50_d;
  logic [RW-1:0] tick_row_q, tick_row_d;

  logic [31:0] wait_ms;
  logic        due, upd, inc;
  logic [7:0]  n_m50;
  logic        n_wrap, tick_wrap;

  // Full 32-bit wrap resets the residues to zero
  assign n_wrap    = (n_hi_q == 16'hffff) && (n_lo_q == 16'hffff);
  assign tick_wrap = (tick_cnt_q == 32'hffff_ffff);

  // Update interval and due check
  always_comb begin
    if (mode_i == MODE_SLEEP)      wait_ms = WAIT_SLEEP;
    else if (mode_i >= MODE_FLASH) wait_ms = WAIT_FLASH;
    else                           wait_ms = WAIT_NORMAL;
    due = time_seen_q > 32'(last_update_q + wait_ms);
    upd = adv_i && due;
    inc = upd && (mode_i <= MODE_SLEEP);
  end

  // Step count mod 50 from its mod 200 residue
  always_comb begin
    n_m50 = n_m200_q;
    if (n_m50 >= 8'd150)     n_m50 = n_m50 - 8'd150;
    else if (n_m50 >= 8'd100) n_m50 = n_m50 - 8'd100;
    else if (n_m50 >= 8'd50)  n_m50 = n_m50 - 8'd50;
  end

  // Control broadcast
  always_comb begin
    ctrl_o.upd       = upd;
    ctrl_o.mode      = mode_i;
    ctrl_o.n_lo      = n_lo_q;
    ctrl_o.n_m16     = n_m16_q;
    ctrl_o.n_m50     = 6'(n_m50);
    ctrl_o.mask_load = upd && (mode_i == MODE_RANDOM_ROWS) && (n_m200_q == 8'd0);
    ctrl_o.fade_load = upd && (mode_i == MODE_FADE) && (n_m50 == 8'd0);
    row_o            = tick_row_q;
    rem_o            = tick_m50_q;
  end

  // Counter next state
  always_comb begin
    n_lo_d        = n_lo_q;
    n_hi_d        = n_hi_q;
    n_m16_d       = n_m16_q;
    n_m200_d      = n_m200_q;
    last_update_d = last_update_q;
    time_seen_d   = time_seen_q;
    tick_cnt_d    = tick_cnt_q;
    tick_m50_d    = tick_m50_q;
    tick_row_d    = tick_row_q;
    if (cfg_clr_i) begin
      n_lo_d   = '0;
      n_hi_d   = '0;
      n_m16_d  = '0;
      n_m200_d = '0;
    end else if (inc) begin
      n_lo_d   = n_lo_q + 16'd1;
      n_hi_d   = (n_lo_q == 16'hffff) ? n_hi_q + 16'd1 : n_hi_q;
      n_m16_d  = (n_lo_q == 16'hffff || n_m16_q == 8'(PERIOD - 1)) ? 8'd0 : n_m16_q + 8'd1;
      n_m200_d = (n_wrap || n_m200_q == 8'(PERIOD - 1)) ? 8'd0 : n_m200_q + 8'd1;
    end
    if (upd) last_update_d = time_seen_q;
    if (adv_i) begin
      time_seen_d = time_ms_i;
      tick_cnt_d  = tick_cnt_q + 32'd1;
      tick_m50_d  = (tick_wrap || tick_m50_q == 6'(PWM_STEPS - 1)) ? 6'd0 : tick_m50_q + 6'd1;
      tick_row_d  = (tick_wrap || tick_row_q == RW'(NUM_ROWS - 1)) ? '0 : tick_row_q + RW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      n_lo_q        <= '0;
      n_hi_q        <= '0;
      n_m16_q       <= '0;
      n_m200_q      <= '0;
      last_update_q <= '0;
      time_seen_q   <= '0;
      tick_cnt_q    <= '0;
      tick_m50_q    <= '0;
      tick_row_q    <= '0;
    end else begin
      n_lo_q        <= n_lo_d;
      n_hi_q        <= n_hi_d;
      n_m16_q       <= n_m16_d;
      n_m200_q      <= n_m200_d;
      last_update_q <= last_update_d;
      time_seen_q   <= time_seen_d;
      tick_cnt_q    <= tick_cnt_d;
      tick_m50_q    <= tick_m50_d;
      tick_row_q    <= tick_row_d;
    end
  end

endmodule
`default_nettype wire

FILE: rtl/lps_cell.sv
`default_nettype none
// ----------------------------------------------------------------------------
// lps_cell
// One grid cell: brightness level, random mask and fade flag with their
// per-mode update.
// ----------------------------------------------------------------------------
module lps_cell
  import lps_pkg::*;
#(
  parameter int ROW = 0,
  parameter int COL = 0
) (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire lps_ctrl_t ctrl_i,
  input  wire logic      cfg_clr_i,
  input  wire logic      pick_lo_i,
  input  wire logic      pick_hi_i,
  output level_t         level_d_o
);

  localparam bit         ODD      = (COL % 2) == 1;
  localparam bit         IS_SLEEP = (ROW == 2) && (COL == 6);
  localparam logic [9:0] ROW_BASE = 10'(ROW_PHASE * ROW);
  // column modes advance the step before use, hence the extra one
  localparam logic [9:0] COL_BASE = 10'(COL_PHASE * (COL / 2) + 1);

  level_t level_q, level_d;
  logic   mask_q, mask_d;
  logic   fade_q, fade_d;

  logic [9:0]        phase;
  logic [16:0]       arg;
  logic [9:0]        pre;
  logic [7:0]        m200, m100, tri100, tri50;
  logic signed [8:0] row_val, col_val, sleep_val, fade_val, val;
  logic              wr;

  // Phase offset for the selected mode
  always_comb begin
    case (ctrl_i.mode)
      MODE_RED_ROWS, MODE_GREEN_ROWS, MODE_RANDOM_ROWS: phase = ROW_BASE + 10'(OFF_ROW);
      MODE_ORANGE_ROWS: phase = ROW_BASE + 10'(OFF_ORANGE);
      MODE_MULTI_ROWS:  phase = ROW_BASE + (ODD ? 10'(OFF_MULTI_ODD) : 10'(OFF_ROW));
      MODE_GREEN_COLS, MODE_ORANGE_COLS, MODE_RED_COLS: phase = COL_BASE + 10'(OFF_COL);
      MODE_MULTI_COLS:  phase = COL_BASE + (ODD ? 10'(OFF_COL_ODD) : 10'(OFF_COL));
      MODE_SLEEP:       phase = 10'(OFF_SLEEP);
      default:          phase = '0;
    endcase
  end

  // Triangle waves: 16-bit argument mod 200, folded via the wrap residue
  always_comb begin
    arg    = {1'b0, ctrl_i.n_lo} + 17'(phase);
    pre    = 10'(ctrl_i.n_m16) + phase - (arg[16] ? WRAP_REM : 10'd0);
    m200   = mod200_f(pre);
    tri100 = (m200 >= 8'd100) ? m200 - 8'd100 : 8'd100 - m200;
    m100   = (m200 >= 8'd100) ? m200 - 8'd100 : m200;
    tri50  = (m100 >= 8'd50) ? m100 - 8'd50 : 8'd50 - m100;
    row_val   = $signed({1'b0, tri100}) - 9'sd50;
    col_val   = $signed({1'b0, tri100}) - 9'sd25;
    sleep_val = $signed({1'b0, tri50}) - 9'sd25;
  end

  // Random mask and fade flag
  always_comb begin
    mask_d = mask_q;
    fade_d = fade_q;
    if (ctrl_i.mask_load) mask_d = pick_lo_i;
    if (ctrl_i.fade_load) begin
      fade_d = !pick_lo_i && !pick_hi_i;
      if (fade_d) mask_d = !mask_q;
    end
  end

  // Fade level
  always_comb begin
    if (fade_d) begin
      fade_val = mask_d ? $signed(9'(ctrl_i.n_m50)) + 9'sd1
                        : 9'sd49 - $signed(9'(ctrl_i.n_m50));
    end else begin
      fade_val = mask_d ? 9'sd50 : 9'sd0;
    end
  end

  // Mode select of written value
  always_comb begin
    wr  = 1'b1;
    val = '0;
    case (ctrl_i.mode)
      MODE_RED_ROWS:    begin wr = !ODD; val = row_val; end
      MODE_ORANGE_ROWS: val = row_val;
      MODE_GREEN_ROWS:  begin wr = ODD; val = row_val; end
      MODE_MULTI_ROWS:  val = row_val;
      MODE_RANDOM_ROWS: val = mask_d ? row_val : 9'sd0;
      MODE_GREEN_COLS:  begin wr = ODD; val = col_val; end
      MODE_ORANGE_COLS: val = col_val;
      MODE_RED_COLS:    begin wr = !ODD; val = col_val; end
      MODE_MULTI_COLS:  val = col_val;
      MODE_FADE:        val = fade_val;
      MODE_SLEEP:       begin wr = IS_SLEEP; val = sleep_val; end
      default:          val = pick_lo_i ? 9'sd50 : 9'sd0;
    endcase
  end

  always_comb begin
    if (cfg_clr_i)              level_d = '0;
    else if (ctrl_i.upd && wr)  level_d = sat_f(val);
    else                        level_d = level_q;
  end

  assign level_d_o = level_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      level_q <= '0;
      mask_q  <= 1'b0;
      fade_q  <= 1'b0;
    end else begin
      level_q <= level_d;
      mask_q  <= mask_d;
      fade_q  <= fade_d;
    end
  end

endmodule
`default_nettype wire

FILE: rtl/led_pattern_scan_pwm.sv
`default_nettype none
// ----------------------------------------------------------------------------
// led_pattern_scan_pwm
// Animated LED grid with row-scanned PWM output.
// ----------------------------------------------------------------------------
// Each request carries a millisecond time and 48 random bits and yields one
// scan result: the active row and its 8 column enables. A request is taken
// into an input register, then the animation step (if due) and the row scan
// are computed into the output register, so a new request can be accepted
// every cycle; throughput is one request per clock while results are taken.
// The result appears at the output once the request has passed the input and
// output registers; a stalled result holds both registers and blocks the
// request side. The update check compares the time of the previous request
// against the last update time.
// Writing mode_select (APB, paddr[2] low) clears all levels and the step count;
// it is meant to happen while no request is in flight.
// ----------------------------------------------------------------------------
module led_pattern_scan_pwm
  import lps_pkg::*;
#(
  parameter int NUM_ROWS = 3,
  parameter int NUM_COLS = 8
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // request channel
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire logic [31:0] time_ms_i,
  input  wire logic [47:0] random_bits_i,
  // result channel
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic [1:0]       row_select_o,
  output logic [7:0]       column_on_o,
  // configuration port
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);

  localparam int  RW        = (NUM_ROWS > 1) ? $clog2(NUM_ROWS) : 1;
  localparam int  SHOW_COLS = (NUM_COLS < 8) ? NUM_COLS : 8;
  localparam logic REG_MODE = 1'b0;

  // Configuration register
  logic [3:0] mode_q;
  logic       cfg_clr;

  assign pready  = 1'b1;
  assign cfg_clr = psel && penable && pwrite && (paddr[2] == REG_MODE);
  assign prdata  = (paddr[2] == REG_MODE) ? {28'd0, mode_q} : 32'd0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= MODE_RED_ROWS;
    end else if (cfg_clr) begin
      mode_q <= pwdata[3:0];
    end
  end

  // Pipeline handshake
  logic        s0_v_q;
  logic [31:0] s0_time_q;
  logic [47:0] s0_rnd_q;
  logic        out_v_q;
  logic [1:0]  row_q;
  logic [7:0]  col_q;
  logic        out_load, adv, accept;

  assign out_load   = !out_v_q || out_ready_i;
  assign adv        = s0_v_q && out_load;
  assign in_ready_o = !s0_v_q || adv;
  assign accept     = in_valid_i && in_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s0_v_q <= 1'b0;
    end else if (in_ready_o) begin
      s0_v_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s0_time_q <= time_ms_i;
      s0_rnd_q  <= random_bits_i;
    end
  end

  // Counters and update control
  lps_ctrl_t     ctrl;
  logic [RW-1:0] row;
  logic [5:0]    rem;

  lps_seq #(
    .NUM_ROWS (NUM_ROWS)
  ) u_seq (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .adv_i     (adv),
    .time_ms_i (s0_time_q),
    .mode_i    (mode_q),
    .cfg_clr_i (cfg_clr),
    .ctrl_o    (ctrl),
    .row_o     (row),
    .rem_o     (rem)
  );

  // Cell grid
  level_t levels_d [NUM_ROWS][NUM_COLS];

  for (genvar j = 0; j < NUM_ROWS; j++) begin : g_row
    for (genvar k = 0; k < NUM_COLS; k++) begin : g_col
      localparam int RB = (j * NUM_COLS + k) % RAND_CELLS;
      lps_cell #(
        .ROW (j),
        .COL (k)
      ) u_cell (
        .clk_i     (clk_i),
        .rst_ni    (rst_ni),
        .ctrl_i    (ctrl),
        .cfg_clr_i (cfg_clr),
        .pick_lo_i (s0_rnd_q[RB]),
        .pick_hi_i (s0_rnd_q[RAND_CELLS + RB]),
        .level_d_o (levels_d[j][k])
      );
    end
  end

  // Row scan: PWM compare on the updated levels
  logic [7:0] col_on;

  for (genvar k = 0; k < 8; k++) begin : g_scan
    if (k < SHOW_COLS) begin : g_on
      assign col_on[k] = $signed({1'b0, rem}) < levels_d[row][k];
    end else begin : g_off
      assign col_on[k] = 1'b0;
    end
  end

  // Result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
    end else if (out_load) begin
      out_v_q <= adv;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      row_q <= 2'(row);
      col_q <= col_on;
    end
  end

  assign out_valid_o  = out_v_q;
  assign row_select_o = row_q;
  assign column_on_o  = col_q;

endmodule
`default_nettype wire
